/* rtl/core/fixed_partition_fit_allocator_assert.svh */
// Assertion macros for the partition allocator
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_ASSERT_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define FPFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("fpfa assertion failed");
`define FPFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("fpfa assertion failed");
`else
`define FPFA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FPFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/fpfa_pkg.sv */
`timescale 1ns / 1ps
package fpfa_pkg;

	localparam int STATUS_W   = 2;
	localparam int IDX_OUT_W  = 5;
	localparam int PORT_SIZE_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	localparam int BCOUNT_W   = 6;

	localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 6'd32;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_ALLOC = 1'b1;

	localparam logic FIT_FIRST = 1'b0;
	localparam logic FIT_WORST = 1'b1;

	localparam logic [STATUS_W-1:0] ST_LOADED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

	typedef struct packed {
		logic ge;
		logic gt;
	} cmp_res_t;

endpackage

/* rtl/core/fpfa_cmp.sv */
`timescale 1ns / 1ps
module fpfa_cmp #(
	parameter int W = 16
) (
	input  logic [W-1:0]         cand,
	input  logic [W-1:0]         req,
	input  logic [W-1:0]         best,
	output fpfa_pkg::cmp_res_t   res,
	output logic [W-1:0]         diff
);
	import fpfa_pkg::*;

	logic [W:0] sub;

	assign sub    = {1'b0, cand} - {1'b0, req};
	assign diff   = sub[W-1:0];
	assign res.ge = ~sub[W];
	assign res.gt = cand > best;

endmodule

/* rtl/core/fpfa_mem.sv */
`timescale 1ns / 1ps
module fpfa_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/fixed_partition_fit_allocator.sv */
`timescale 1ns / 1ps
// Fixed partition allocator. A load transaction writes one block size and frees
// that block; its result is published from the finish state once the output is
// free. An allocate transaction scans blocks 0 through the effective block count
// minus one, reading one entry of the size memory per cycle through a single
// compare/subtract unit, and publishes its result the same way; first fit stops
// at the first fitting free block. One transaction is in work at a time; a
// finished result may wait at the output while the next transaction is accepted.
// Sizes are held at SIZE_BITS bits; the block size memory holds no defined value
// for a block until it has been loaded.
module fixed_partition_fit_allocator #(
	parameter int NUM_BLOCKS = 32,
	parameter int SIZE_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                func,
	input  logic [4:0]                          block_slot,
	input  logic [fpfa_pkg::PORT_SIZE_W-1:0]    size,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [fpfa_pkg::STATUS_W-1:0]       status,
	output logic [fpfa_pkg::IDX_OUT_W-1:0]      block_index,
	output logic [fpfa_pkg::PORT_SIZE_W-1:0]    block_size,
	output logic [fpfa_pkg::PORT_SIZE_W-1:0]    leftover,
	input  logic                                cfg_we,
	input  logic [fpfa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fpfa_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import fpfa_pkg::*;

	`include "fixed_partition_fit_allocator_assert.svh"

	localparam int AW    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]            state_q;
	logic                  fit_mode_q;
	logic [BCOUNT_W-1:0]   block_count_q;
	logic [CNT_W-1:0]      limit_c;
	logic [CNT_W-1:0]      limit_q;
	logic [CNT_W-1:0]      rd_idx_q;
	logic [SIZE_BITS-1:0]  req_q;
	logic                  is_load_q;
	logic                  found_q;
	logic [AW-1:0]         best_idx_q;
	logic [SIZE_BITS-1:0]  best_size_q;
	logic [SIZE_BITS-1:0]  left_q;
	logic                  ev_v_s1;
	logic [AW-1:0]         ev_idx_s1;
	logic                  used_s1;
	logic [NUM_BLOCKS-1:0] used_q;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [IDX_OUT_W-1:0]  block_index_q;
	logic [PORT_SIZE_W-1:0] block_size_q;
	logic [PORT_SIZE_W-1:0] leftover_q;

	logic                  in_acc;
	logic                  load_ok;
	logic                  do_load;
	logic                  issue;
	logic [AW-1:0]         rd_addr;
	logic [SIZE_BITS-1:0]  rd_data;
	cmp_res_t              cmp;
	logic [SIZE_BITS-1:0]  diff;
	logic                  hit;
	logic                  take;
	logic                  scan_end;
	logic                  out_free;
	logic                  publish;

	assign limit_c = (32'(block_count_q) > 32'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
	                                                         : CNT_W'(block_count_q);
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign load_ok  = (32'(block_slot) < 32'(NUM_BLOCKS));
	assign do_load  = in_acc && (func == FUNC_LOAD) && load_ok;
	assign issue    = (state_q == S_SCAN) && (rd_idx_q < limit_q);
	assign rd_addr  = rd_idx_q[AW-1:0];
	assign hit      = ev_v_s1 && !used_s1 && cmp.ge;
	assign take     = hit && (!found_q || ((fit_mode_q == FIT_WORST) && cmp.gt));
	assign scan_end = (state_q == S_SCAN) &&
	                  ((take && (fit_mode_q == FIT_FIRST)) || (!ev_v_s1 && !issue));
	assign out_free = !out_valid_q || out_ready;
	assign publish  = (state_q == S_FIN) && out_free;

	fpfa_mem #(
		.DEPTH (NUM_BLOCKS),
		.AW    (AW),
		.DW    (SIZE_BITS)
	) u_mem (
		.clk     (clk),
		.wr_en   (do_load),
		.wr_addr (AW'(block_slot)),
		.wr_data (SIZE_BITS'(size)),
		.rd_en   (issue),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	fpfa_cmp #(
		.W (SIZE_BITS)
	) u_cmp (
		.cand (rd_data),
		.req  (req_q),
		.best (best_size_q),
		.res  (cmp),
		.diff (diff)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= FIT_FIRST;
			block_count_q <= BCOUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIT_MODE:    fit_mode_q    <= cfg_data[0];
				REG_BLOCK_COUNT: block_count_q <= cfg_data[BCOUNT_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_idx_q    <= '0;
			ev_v_s1     <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			used_q      <= '0;
		end else begin
			ev_v_s1 <= issue;
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (do_load) begin
				used_q[AW'(block_slot)] <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						rd_idx_q <= '0;
						found_q  <= 1'b0;
						state_q  <= (func == FUNC_LOAD) ? S_FIN : S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (take) begin
						found_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (found_q) begin
							used_q[best_idx_q] <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q     <= SIZE_BITS'(size);
			limit_q   <= limit_c;
			is_load_q <= (func == FUNC_LOAD);
		end
		if (issue) begin
			ev_idx_s1 <= rd_addr;
			used_s1   <= used_q[rd_addr];
		end
		if ((state_q == S_SCAN) && take) begin
			best_idx_q  <= ev_idx_s1;
			best_size_q <= rd_data;
			left_q      <= diff;
		end
		if (publish) begin
			if (is_load_q) begin
				status_q <= ST_LOADED;
			end else if (found_q) begin
				status_q <= ST_GRANTED;
			end else begin
				status_q <= ST_NOFIT;
			end
			block_index_q <= found_q ? IDX_OUT_W'(best_idx_q) : '0;
			block_size_q  <= found_q ? PORT_SIZE_W'(best_size_q) : '0;
			leftover_q    <= found_q ? PORT_SIZE_W'(left_q) : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign block_index = block_index_q;
	assign block_size  = block_size_q;
	assign leftover    = leftover_q;

	`FPFA_ASSERT_NOW(a_scan_bound, clk, arst_n, state_q == S_SCAN, rd_idx_q <= limit_q)
	`FPFA_ASSERT_NOW(a_first_fit_stops, clk, arst_n, (state_q == S_SCAN) && found_q,
		fit_mode_q == FIT_WORST)
	`FPFA_ASSERT_NOW(a_nogrant_zero, clk, arst_n, out_valid_q && (status_q != ST_GRANTED),
		(block_index_q == '0) && (block_size_q == '0) && (leftover_q == '0))
	`FPFA_ASSERT_NEXT(a_load_frees, clk, arst_n, (state_q == S_IDLE) && do_load,
		(state_q == S_FIN) && !found_q)

endmodule
